### design/kphc_pkg.sv
// kphc_pkg: shared types, codes and constants of the key press/hold classifier.
// Used by kphc_classify, key_press_hold_classifier and the verification benches; depends on nothing.

package kphc_pkg;

  // Number of tracked keys; key_index values at or above it are ignored.
  localparam int NumKeys = 128;
  localparam int KeyAw   = (NumKeys > 1) ? $clog2(NumKeys) : 1;

  // Sampled key actions.
  localparam logic [1:0] ActNone    = 2'd0;
  localparam logic [1:0] ActPress   = 2'd1;
  localparam logic [1:0] ActRelease = 2'd2;

  // Bit positions in the per-key flag nibble.
  localparam int FlPress   = 0;
  localparam int FlHold    = 1;
  localparam int FlRelease = 2;
  localparam int FlDouble  = 3;

  // Configuration register indexes.
  localparam logic [1:0] RegHoldMin    = 2'd0;
  localparam logic [1:0] RegDoubleMin  = 2'd1;
  localparam logic [1:0] RegDoubleMax  = 2'd2;
  localparam logic [1:0] RegReleaseMin = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] HoldMinRst    = 16'd300;
  localparam logic [15:0] DoubleMinRst  = 16'd20;
  localparam logic [15:0] DoubleMaxRst  = 16'd250;
  localparam logic [15:0] ReleaseMinRst = 16'd0;

  typedef struct packed {
    logic [15:0] hold_min;
    logic [15:0] double_min;
    logic [15:0] double_max;
    logic [15:0] release_min;
  } cfg_t;

  // One entry of the per-key store.
  typedef struct packed {
    logic [3:0]  flags;
    logic [31:0] stamp;
  } key_entry_t;

  // Decision of the classifier for one sample.
  typedef struct packed {
    logic        valid;
    logic [3:0]  flags;
    logic [31:0] time_ms;
    logic [31:0] dur_ms;
  } key_event_t;

endpackage

### design/kphc_classify.sv
// kphc_classify: combinational decision for one key sample against the key's
// last recorded event. Depends on kphc_pkg.

module kphc_classify (
  input  logic                 in_range_i,
  input  logic [1:0]           action_i,
  input  logic [31:0]          now_ms_i,
  input  kphc_pkg::key_entry_t entry_i,
  input  kphc_pkg::cfg_t       cfg_i,
  output kphc_pkg::key_event_t event_o
);

  logic [31:0] dt;
  logic        down;
  logic        is_double;

  assign dt   = now_ms_i - entry_i.stamp;
  assign down = entry_i.flags[kphc_pkg::FlPress] | entry_i.flags[kphc_pkg::FlHold];
  assign is_double = entry_i.flags[kphc_pkg::FlRelease]
                   && (dt >= 32'(cfg_i.double_min))
                   && (dt <= 32'(cfg_i.double_max));

  always_comb begin
    event_o = '0;
    if (in_range_i) begin
      case (action_i)
        kphc_pkg::ActPress: begin
          if (down) begin
            // held key keeps reporting hold against the original press time
            if ((entry_i.flags[kphc_pkg::FlPress] && (dt >= 32'(cfg_i.hold_min)))
                || entry_i.flags[kphc_pkg::FlHold]) begin
              event_o.valid                     = 1'b1;
              event_o.flags[kphc_pkg::FlHold]   = 1'b1;
              event_o.time_ms                   = entry_i.stamp;
              event_o.dur_ms                    = dt;
            end
          end else begin
            event_o.valid                       = 1'b1;
            event_o.flags[kphc_pkg::FlPress]    = 1'b1;
            event_o.flags[kphc_pkg::FlDouble]   = is_double;
            event_o.time_ms                     = now_ms_i;
          end
        end
        kphc_pkg::ActRelease: begin
          if (down && (dt >= 32'(cfg_i.release_min))) begin
            event_o.valid                       = 1'b1;
            event_o.flags[kphc_pkg::FlRelease]  = 1'b1;
            event_o.time_ms                     = now_ms_i;
            event_o.dur_ms                      = dt;
          end
        end
        default: begin
          event_o = '0;
        end
      endcase
    end
  end

endmodule

### design/key_press_hold_classifier.sv
// key_press_hold_classifier: top level; per-key state store, read stage,
// forwarding, output register and configuration registers.
// Depends on kphc_pkg and kphc_classify.
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  -------------------------------
//  input     in         in_valid_i / in_stall_o    key_index, key_action, now, poll
//  result    out        out_valid_o / out_stall_i  out_key, ev_* fields
//  config    in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One sample per cycle sustained while the result side does not stall; the store is
// read at input transfer, then decision and write-back follow as the result loads.
// The store is a one-read, one-write memory with registered read data; the
// entry written in the cycle of a read is forwarded from a last-write register.
// Reset clears per-key valid bits at once, so no clearing pass is needed; an
// entry never written reads as flags none, stamp zero.
// A stall on the result side backs up through the decision stage to in_stall_o.

module key_press_hold_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // samples
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [6:0]  key_index_i,
  input  logic [1:0]  key_action_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] poll_number_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  out_key_o,
  output logic        ev_valid_o,
  output logic        ev_press_o,
  output logic        ev_hold_o,
  output logic        ev_release_o,
  output logic        ev_double_o,
  output logic [31:0] ev_time_ms_o,
  output logic [31:0] ev_duration_ms_o,
  output logic [31:0] ev_poll_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  kphc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_min    <= kphc_pkg::HoldMinRst;
      cfg_q.double_min  <= kphc_pkg::DoubleMinRst;
      cfg_q.double_max  <= kphc_pkg::DoubleMaxRst;
      cfg_q.release_min <= kphc_pkg::ReleaseMinRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kphc_pkg::RegHoldMin:    cfg_q.hold_min    <= cfg_data_i;
        kphc_pkg::RegDoubleMin:  cfg_q.double_min  <= cfg_data_i;
        kphc_pkg::RegDoubleMax:  cfg_q.double_max  <= cfg_data_i;
        kphc_pkg::RegReleaseMin: cfg_q.release_min <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic s1_adv;     // decision stage moves into the output register
  logic in_xfer;
  logic out_load;

  assign s1_adv     = !out_valid_o || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_load   = s1_valid_q && s1_adv;

  // ---------------------------------------------------------------------------
  // Read stage: store read issued on input transfer
  // ---------------------------------------------------------------------------
  logic [kphc_pkg::KeyAw-1:0] in_addr;
  assign in_addr = kphc_pkg::KeyAw'(key_index_i);

  kphc_pkg::key_entry_t ent_mem_q [kphc_pkg::NumKeys];
  kphc_pkg::key_entry_t rd_data_q;

  logic [6:0]  s1_key_q;
  logic [1:0]  s1_action_q;
  logic [31:0] s1_now_q;
  logic [31:0] s1_poll_q;
  logic        s1_in_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_key_q      <= key_index_i;
      s1_action_q   <= key_action_i;
      s1_now_q      <= now_ms_i;
      s1_poll_q     <= poll_number_i;
      s1_in_range_q <= (32'(key_index_i) < kphc_pkg::NumKeys);
      rd_data_q     <= ent_mem_q[in_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Decision stage: pick the current entry, classify, write back
  // ---------------------------------------------------------------------------
  logic [kphc_pkg::KeyAw-1:0] s1_addr;
  assign s1_addr = kphc_pkg::KeyAw'(s1_key_q);

  logic [kphc_pkg::NumKeys-1:0] ent_valid_q;
  logic                         fwd_valid_q;
  logic [kphc_pkg::KeyAw-1:0]   fwd_addr_q;
  kphc_pkg::key_entry_t         fwd_data_q;
  kphc_pkg::key_entry_t         cur_entry;
  kphc_pkg::key_event_t         s1_event;
  kphc_pkg::key_entry_t         wr_data;
  logic                         wr_en;

  // The last write always holds the newest value of its key, whether or not
  // the read of this sample already saw it.
  always_comb begin
    if (!ent_valid_q[s1_addr]) begin
      cur_entry = '0;
    end else if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
      cur_entry = fwd_data_q;
    end else begin
      cur_entry = rd_data_q;
    end
  end

  kphc_classify u_classify (
    .in_range_i (s1_in_range_q),
    .action_i   (s1_action_q),
    .now_ms_i   (s1_now_q),
    .entry_i    (cur_entry),
    .cfg_i      (cfg_q),
    .event_o    (s1_event)
  );

  assign wr_en         = out_load && s1_event.valid;
  assign wr_data.flags = s1_event.flags;
  assign wr_data.stamp = s1_event.time_ms;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_mem_q[s1_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      fwd_valid_q <= 1'b0;
    end else if (wr_en) begin
      ent_valid_q[s1_addr] <= 1'b1;
      fwd_valid_q          <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                 out_valid_q;
  logic [6:0]           out_key_q;
  kphc_pkg::key_event_t out_event_q;
  logic [31:0]          out_poll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_key_q   <= s1_key_q;
      out_event_q <= s1_event;
      out_poll_q  <= s1_event.valid ? s1_poll_q : 32'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_key_o        = out_key_q;
  assign ev_valid_o       = out_event_q.valid;
  assign ev_press_o       = out_event_q.flags[kphc_pkg::FlPress];
  assign ev_hold_o        = out_event_q.flags[kphc_pkg::FlHold];
  assign ev_release_o     = out_event_q.flags[kphc_pkg::FlRelease];
  assign ev_double_o      = out_event_q.flags[kphc_pkg::FlDouble];
  assign ev_time_ms_o     = out_event_q.time_ms;
  assign ev_duration_ms_o = out_event_q.dur_ms;
  assign ev_poll_o        = out_poll_q;

`ifndef SYNTH
  // an empty output register never backs up the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty output register");

  // at most one of press, hold, release per event
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({ev_press_o, ev_hold_o, ev_release_o}))
    else $error("conflicting event flags");

  // double only rides on a press
  a_double_with_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ev_double_o) |-> ev_press_o)
    else $error("double flag without press");

  // write-back happens only for a recorded event and is captured for forwarding
  a_fwd_tracks_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (fwd_valid_q && (fwd_addr_q == $past(s1_addr))
               && out_valid_q && ev_valid_o))
    else $error("forwarding register lost a write");
`endif

endmodule

### verif/key_press_hold_classifier_chk.sv
// key_press_hold_classifier_chk: watches the sample, result and config channels.
// It predicts each result from its own per-key state and compares it field by field.
// Depends on kphc_pkg.

module key_press_hold_classifier_chk
  import kphc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [6:0]  key_index_i,
  input  logic [1:0]  key_action_i,
  input  logic [31:0] now_ms_i,
  input  logic [31:0] poll_number_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [6:0]  out_key_i,
  input  logic        ev_valid_i,
  input  logic        ev_press_i,
  input  logic        ev_hold_i,
  input  logic        ev_release_i,
  input  logic        ev_double_i,
  input  logic [31:0] ev_time_ms_i,
  input  logic [31:0] ev_duration_ms_i,
  input  logic [31:0] ev_poll_i,
  output int          fail_o,
  output int          pending_o
);

  typedef struct packed {
    logic [6:0]  key;
    logic        valid;
    logic        press;
    logic        hold;
    logic        rel;
    logic        dbl;
    logic [31:0] ts;
    logic [31:0] dur;
    logic [31:0] poll;
  } key_event_exp_t;

  cfg_t           cfg;
  logic [3:0]     key_flags_mem [NumKeys];
  logic [31:0]    key_stamp_mem [NumKeys];
  key_event_exp_t event_q [$];
  int             n_fail;
  int             n_pending;

  assign fail_o    = n_fail;
  assign pending_o = n_pending;

  // Classify one sample and update the key's entry when an event is recorded.
  function automatic key_event_exp_t classify_sample(logic [6:0] key, logic [1:0] act,
                                                     logic [31:0] now, logic [31:0] poll);
    key_event_exp_t r;
    logic [3:0]     fl;
    logic [31:0]    st;
    logic [31:0]    dt;
    logic           down;
    logic           hit;
    logic [3:0]     nfl;
    logic [31:0]    nts;
    logic [31:0]    ndur;
    r     = '0;
    r.key = key;
    hit   = 1'b0;
    nfl   = '0;
    nts   = '0;
    ndur  = '0;
    if (int'(key) < NumKeys) begin
      fl   = key_flags_mem[key];
      st   = key_stamp_mem[key];
      dt   = now - st;               // wraps modulo 2^32
      down = fl[FlPress] | fl[FlHold];
      if (act == ActPress) begin
        if (down) begin
          if ((fl[FlPress] && dt >= 32'(cfg.hold_min)) || fl[FlHold]) begin
            hit          = 1'b1;
            nfl[FlHold]  = 1'b1;
            nts          = st;       // hold keeps the original press time
            ndur         = dt;
          end
        end else begin
          hit          = 1'b1;
          nfl[FlPress] = 1'b1;
          nts          = now;
          if (fl[FlRelease] && dt >= 32'(cfg.double_min) && dt <= 32'(cfg.double_max))
            nfl[FlDouble] = 1'b1;
        end
      end else if (act == ActRelease) begin
        if (down && dt >= 32'(cfg.release_min)) begin
          hit            = 1'b1;
          nfl[FlRelease] = 1'b1;
          nts            = now;
          ndur           = dt;
        end
      end
      if (hit) begin
        key_flags_mem[key] = nfl;
        key_stamp_mem[key] = nts;
      end
    end
    if (hit) begin
      r.valid = 1'b1;
      r.press = nfl[FlPress];
      r.hold  = nfl[FlHold];
      r.rel   = nfl[FlRelease];
      r.dbl   = nfl[FlDouble];
      r.ts    = nts;
      r.dur   = ndur;
      r.poll  = poll;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    key_event_exp_t want;
    if (!rst_ni) begin
      cfg.hold_min    = HoldMinRst;
      cfg.double_min  = DoubleMinRst;
      cfg.double_max  = DoubleMaxRst;
      cfg.release_min = ReleaseMinRst;
      for (int i = 0; i < NumKeys; i++) begin
        key_flags_mem[i] = '0;
        key_stamp_mem[i] = '0;
      end
      event_q.delete();
      n_pending = 0;
    end else begin
      // Config first; the stimulus never writes while samples are in flight.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegHoldMin:    cfg.hold_min    = cfg_data_i;
          RegDoubleMin:  cfg.double_min  = cfg_data_i;
          RegDoubleMax:  cfg.double_max  = cfg_data_i;
          RegReleaseMin: cfg.release_min = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        event_q.push_back(classify_sample(key_index_i, key_action_i, now_ms_i,
                                          poll_number_i));
      if (out_valid_i && !out_stall_i) begin
        if (event_q.size() == 0) begin
          $error("result transfer with nothing expected (out_key %0h)", out_key_i);
          n_fail++;
        end else begin
          want = event_q.pop_front();
          check_field("out_key", 32'(want.key), 32'(out_key_i));
          check_field("ev_valid", 32'(want.valid), 32'(ev_valid_i));
          check_field("ev_press", 32'(want.press), 32'(ev_press_i));
          check_field("ev_hold", 32'(want.hold), 32'(ev_hold_i));
          check_field("ev_release", 32'(want.rel), 32'(ev_release_i));
          check_field("ev_double", 32'(want.dbl), 32'(ev_double_i));
          check_field("ev_time_ms", want.ts, ev_time_ms_i);
          check_field("ev_duration_ms", want.dur, ev_duration_ms_i);
          check_field("ev_poll", want.poll, ev_poll_i);
        end
      end
      n_pending = event_q.size();
    end
  end

  initial n_fail = 0;

endmodule

### verif/key_press_hold_classifier_tb.sv
// key_press_hold_classifier_tb: stimulus and verdict for the key classifier.
// Drives directed and random key samples under bursty input and random stalls.
// Depends on kphc_pkg, key_press_hold_classifier and key_press_hold_classifier_chk.

module key_press_hold_classifier_tb;
  import kphc_pkg::*;

  // The action field is two bits wide; the spare code must act as none.
  localparam logic [1:0] ActSpare = 2'd3;
  // Cycles without any transfer before the run is declared hung.
  localparam int IdleLimit = 4000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [6:0]  key_index;
  logic [1:0]  key_action;
  logic [31:0] now_ms;
  logic [31:0] poll_number;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  out_key;
  logic        ev_valid;
  logic        ev_press;
  logic        ev_hold;
  logic        ev_release;
  logic        ev_double;
  logic [31:0] ev_time_ms;
  logic [31:0] ev_duration_ms;
  logic [31:0] ev_poll;

  int          n_fail;
  int          n_pending;
  int          idle_cycles;

  // Millisecond time stamp of the random samples, advanced by a random step per sample.
  logic [31:0] sim_ms;
  // Four keys per phase get most of the traffic so press, hold, release and
  // double press sequences actually build up on them.
  logic [6:0]  key_pool [4];

  key_press_hold_classifier u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .key_index_i      (key_index),
    .key_action_i     (key_action),
    .now_ms_i         (now_ms),
    .poll_number_i    (poll_number),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_key_o        (out_key),
    .ev_valid_o       (ev_valid),
    .ev_press_o       (ev_press),
    .ev_hold_o        (ev_hold),
    .ev_release_o     (ev_release),
    .ev_double_o      (ev_double),
    .ev_time_ms_o     (ev_time_ms),
    .ev_duration_ms_o (ev_duration_ms),
    .ev_poll_o        (ev_poll)
  );

  key_press_hold_classifier_chk u_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .key_index_i      (key_index),
    .key_action_i     (key_action),
    .now_ms_i         (now_ms),
    .poll_number_i    (poll_number),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_key_i        (out_key),
    .ev_valid_i       (ev_valid),
    .ev_press_i       (ev_press),
    .ev_hold_i        (ev_hold),
    .ev_release_i     (ev_release),
    .ev_double_i      (ev_double),
    .ev_time_ms_i     (ev_time_ms),
    .ev_duration_ms_i (ev_duration_ms),
    .ev_poll_i        (ev_poll),
    .fail_o           (n_fail),
    .pending_o        (n_pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Receiver: stall mode is picked anew whenever a random countdown runs out:
  // never, light random, heavy random, or a fixed on/off rhythm.
  int stall_mode;
  int stall_left;
  int stall_phase;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 50;
      stall_phase <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 99) < 25);
        2:       out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= ((stall_phase % 5) < 2);
      endcase
    end
  end

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL key_press_hold_classifier");
      $finish;
    end
  end

  // Present one sample and hold it until the transfer edge.
  task automatic put_sample(logic [6:0] key, logic [1:0] act, logic [31:0] now,
                            logic [31:0] poll);
    in_valid    <= 1'b1;
    key_index   <= key;
    key_action  <= act;
    now_ms      <= now;
    poll_number <= poll;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait for every outstanding result, plus a little slack.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Rewrite all four thresholds, one per cycle, while the block is idle.
  task automatic set_thresholds(logic [15:0] hold_min, logic [15:0] dbl_min,
                                logic [15:0] dbl_max, logic [15:0] rel_min);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= RegHoldMin;
    cfg_data <= hold_min;
    @(posedge clk);
    cfg_idx  <= RegDoubleMin;
    cfg_data <= dbl_min;
    @(posedge clk);
    cfg_idx  <= RegDoubleMax;
    cfg_data <= dbl_max;
    @(posedge clk);
    cfg_idx  <= RegReleaseMin;
    cfg_data <= rel_min;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly short steps, sometimes long ones past any threshold, rarely a jump
  // anywhere in the 32-bit range so wrapped differences get exercised.
  function automatic logic [31:0] next_ms_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)      return $urandom_range(0, 40);
    else if (r < 90) return $urandom_range(0, 400);
    else if (r < 98) return $urandom_range(0, 80000);
    else             return $urandom;
  endfunction

  // Random traffic in bursts; the last sample is left for drain() to close.
  task automatic run_random(int n_items);
    int          i;
    int          r;
    int          burst;
    logic [6:0]  key;
    logic [1:0]  act;
    for (i = 0; i < 4; i++) key_pool[i] = 7'($urandom_range(0, 127));
    burst = $urandom_range(1, 40);
    for (i = 0; i < n_items; i++) begin
      r   = $urandom_range(0, 99);
      key = (r < 75) ? key_pool[$urandom_range(0, 3)] : 7'($urandom_range(0, 127));
      r   = $urandom_range(0, 99);
      if (r < 50)      act = ActPress;
      else if (r < 80) act = ActRelease;
      else if (r < 92) act = ActNone;
      else             act = ActSpare;
      sim_ms = sim_ms + next_ms_step();
      put_sample(key, act, sim_ms, $urandom);
      burst--;
      if (burst == 0 && i < n_items - 1) begin
        // Occasionally a long unbroken stretch, otherwise short bursts.
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
                                               $urandom_range(1, 40);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = RegHoldMin;
    cfg_data    = '0;
    in_valid    = 1'b0;
    key_index   = '0;
    key_action  = ActNone;
    now_ms      = '0;
    poll_number = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset thresholds (hold 300, double 20..250, release 0).
    put_sample(7'd0, ActNone,    32'd0,   32'd0);         // nothing recorded
    put_sample(7'd0, ActSpare,   32'd5,   32'hFFFF_FFFF); // spare code acts as none
    put_sample(7'd0, ActRelease, 32'd10,  $urandom);      // release of an up key
    put_sample(7'd0, ActPress,   32'd100, $urandom);      // plain press
    put_sample(7'd0, ActPress,   32'd150, $urandom);      // down, too early to hold
    put_sample(7'd0, ActPress,   32'd400, $urandom);      // hold exactly at threshold
    put_sample(7'd0, ActPress,   32'd410, $urandom);      // held key keeps holding
    put_sample(7'd0, ActRelease, 32'd500, $urandom);
    put_sample(7'd0, ActPress,   32'd519, $urandom);      // gap below double window
    put_sample(7'd0, ActRelease, 32'd530, $urandom);
    put_sample(7'd0, ActPress,   32'd550, $urandom);      // double at window start
    put_sample(7'd0, ActRelease, 32'd560, $urandom);
    put_sample(7'd0, ActPress,   32'd810, $urandom);      // double at window end
    put_sample(7'd0, ActRelease, 32'd820, $urandom);
    put_sample(7'd0, ActPress,   32'd1071, $urandom);     // just past the window
    // Time wrapping through zero on the top key.
    put_sample(7'd127, ActPress,   32'hFFFF_FFF0, 32'hFFFF_FFFF);
    put_sample(7'd127, ActPress,   32'h0000_0120, 32'h0000_0000);
    put_sample(7'd127, ActRelease, 32'h0000_0200, 32'hAAAA_5555);

    // Release rejected when it comes too soon after the press.
    set_thresholds(HoldMinRst, DoubleMinRst, DoubleMaxRst, 16'd50);
    put_sample(7'd5, ActPress,   32'd1000, $urandom);
    put_sample(7'd5, ActRelease, 32'd1020, $urandom);     // too early, ignored
    put_sample(7'd5, ActRelease, 32'd1050, $urandom);     // exactly at minimum

    // Random phases over several threshold settings, extremes included.
    sim_ms = $urandom;
    set_thresholds(HoldMinRst, DoubleMinRst, DoubleMaxRst, ReleaseMinRst);
    run_random(450);
    set_thresholds(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(350);
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(300);
    set_thresholds(16'd100, 16'd0, 16'hFFFF, 16'd30);
    run_random(450);
    set_thresholds(16'($urandom_range(0, 600)), 16'($urandom_range(0, 100)),
                   16'($urandom_range(50, 400)), 16'($urandom_range(0, 80)));
    run_random(450);

    drain();
    repeat (10) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("PASS key_press_hold_classifier");
    end else begin
      $display("FAIL key_press_hold_classifier");
    end
    $finish;
  end

endmodule

### files.f
design/kphc_pkg.sv
design/kphc_classify.sv
design/key_press_hold_classifier.sv
verif/key_press_hold_classifier_chk.sv
verif/key_press_hold_classifier_tb.sv
